### rtl/sgnms_pkg.sv
package sgnms_pkg;

  localparam int PIX_W = 8;
  localparam int MAG_W = 8;
  localparam int DIR_W = 2;
  // Largest Sobel term is 4 * 255, so the absolute gradient fits in 10 bits.
  localparam int ABS_W = 10;
  localparam int SQ_W  = 21;

  localparam logic [63:0] TAN22_Q40 = 64'h6A09E667F4;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_UPPER_THRESHOLD = 2'd2,
    REG_LOWER_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_code_t;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic [MAG_W-1:0] mag;
  } grad_t;

  // Window indexed [row][column]; row 0 is the oldest line, column 0 the oldest pixel.
  typedef logic [2:0][2:0][PIX_W-1:0] pix_win_t;
  typedef grad_t [2:0][2:0] grad_win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_GRAD,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_MUL,
    G_DIR,
    G_ROOT,
    G_DONE
  } gstate_t;

endpackage

### rtl/sobel_gradient_nonmax_suppress.sv
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tdata: pixel[7:0]; tuser: mode
// m_axis    out  tdata: edge_magnitude[7:0], direction[9:8], is_strong[10],
//                is_weak[11], zero[15:12]; tlast: end_of_frame
// apb       in   registers image_width, image_height, upper/lower_threshold
//
// After a frame pixel or flush beat is taken, s_axis_tready stays low while the
// beat passes the read, gradient, store and output states, so no new beat is
// taken until it is done. The gradient unit works in multiply, direction and
// bit-serial square root steps. A drain beat before the frame end is taken and dropped.
// Reset is synchronous, clears the position and handshake state and sets the
// registers to their defaults; the line memories need no clearing. A stalled result
// waits in the output register while the next beat is already being worked on; if it
// still waits when the next result is ready, the input stays blocked until it is taken.
module sobel_gradient_nonmax_suppress import sgnms_pkg::*; #(
  parameter int MAX_LINE      = 2048,
  parameter int MAX_LINES     = 4096,
  parameter int TAN_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // edge_magnitude, direction, is_strong, is_weak
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int RW = $clog2(MAX_LINES + 3);

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  upper_threshold, lower_threshold;

  logic [CW:0]   frame_w;
  logic [RW-1:0] frame_h;
  logic [31:0]   w32, h32;

  state_t state, state_next;

  logic [CW:0]   ct;
  logic [RW-1:0] rt;
  logic          accept, proc, cfg_wr, size_wr;
  logic          ge2, g_int_c, s_valid_c, s_int_c, eof_c, wrap_c;
  logic [CW-1:0] cg_c;

  logic [CW-1:0]    it_ct, it_cg;
  logic [PIX_W-1:0] it_pix;
  logic             it_gint, it_svalid, it_sint, it_eof;

  pix_win_t  pwin;
  grad_win_t gwin;
  logic [2*PIX_W-1:0] prd;
  logic [19:0]        grd;
  logic               grad_start, grad_done;
  grad_t              grad, gnew;

  grad_t            cen;
  logic [MAG_W-1:0] n1, n2, m_c;
  logic [DIR_W-1:0] d_c;
  logic             out_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign size_wr = cfg_wr && ((cfg_reg_t'(paddr[3:2]) == REG_IMAGE_WIDTH) ||
                              (cfg_reg_t'(paddr[3:2]) == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 12'd640;
      image_height    <= 13'd480;
      upper_threshold <= 8'd60;
      lower_threshold <= 8'd20;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_IMAGE_WIDTH:     image_width     <= pwdata[11:0];
        REG_IMAGE_HEIGHT:    image_height    <= pwdata[12:0];
        REG_UPPER_THRESHOLD: upper_threshold <= pwdata[7:0];
        REG_LOWER_THRESHOLD: lower_threshold <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_IMAGE_WIDTH:     prdata = 32'(image_width);
      REG_IMAGE_HEIGHT:    prdata = 32'(image_height);
      REG_UPPER_THRESHOLD: prdata = 32'(upper_threshold);
      REG_LOWER_THRESHOLD: prdata = 32'(lower_threshold);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    w32 = 32'(image_width);
    if (w32 < 32'd3) begin
      w32 = 32'd3;
    end else if (w32 > 32'(MAX_LINE)) begin
      w32 = 32'(MAX_LINE);
    end
    h32 = 32'(image_height);
    if (h32 < 32'd3) begin
      h32 = 32'd3;
    end else if (h32 > 32'(MAX_LINES)) begin
      h32 = 32'(MAX_LINES);
    end
    frame_w = w32[CW:0];
    frame_h = h32[RW-1:0];
  end

  // Position decode. The gradient lags one line plus one pixel and the
  // suppression two lines plus two pixels behind the incoming position.
  always_comb begin
    ge2       = ct >= (CW+1)'(2);
    proc      = (rt >= frame_h) || !s_axis_tuser;
    g_int_c   = ge2 && (rt >= RW'(2)) && (rt <= frame_h - RW'(1));
    s_valid_c = ge2 ? ((rt >= RW'(2)) && (rt <= frame_h + RW'(1)))
                    : ((rt >= RW'(3)) && (rt <= frame_h + RW'(2)));
    if (ct >= (CW+1)'(3)) begin
      s_int_c = (rt >= RW'(3)) && (rt <= frame_h);
    end else if (ct == '0) begin
      s_int_c = (rt >= RW'(4)) && (rt <= frame_h + RW'(1));
    end else begin
      s_int_c = 1'b0;
    end
    eof_c  = (ct == (CW+1)'(1)) && (rt == frame_h + RW'(2));
    wrap_c = (rt >= frame_h + RW'(2)) && (ct != '0);
    cg_c   = (ct != '0) ? CW'(ct - (CW+1)'(1)) : CW'(frame_w - (CW+1)'(1));
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      rt <= '0;
      ct <= '0;
    end else if (accept && proc) begin
      if (wrap_c) begin
        rt <= '0;
        ct <= '0;
      end else if (ct + (CW+1)'(1) >= frame_w) begin
        ct <= '0;
        rt <= rt + RW'(1);
      end else begin
        ct <= ct + (CW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    grad_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && proc) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_START;
      ST_START: begin
        grad_start = 1'b1;
        state_next = ST_GRAD;
      end
      ST_GRAD: begin
        if (grad_done) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: state_next = ST_OUT;
      ST_OUT: begin
        if (!it_svalid) begin
          state_next = ST_IDLE;
        end else if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && proc) begin
      it_ct     <= ct[CW-1:0];
      it_cg     <= cg_c;
      it_pix    <= s_axis_tdata;
      it_gint   <= g_int_c;
      it_svalid <= s_valid_c;
      it_sint   <= s_int_c;
      it_eof    <= eof_c;
    end
  end

  // Each pixel line word holds the two previous lines, older one on top.
  sgnms_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_LINE)) u_pixel_ram (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (it_ct),
    .wdata ({prd[PIX_W-1:0], it_pix}),
    .re    (accept && proc),
    .raddr (ct[CW-1:0]),
    .rdata (prd)
  );

  sgnms_ram #(.WIDTH(20), .DEPTH(MAX_LINE)) u_grad_ram (
    .clk   (clk),
    .we    (state == ST_STORE),
    .waddr (it_cg),
    .wdata ({grd[9:0], gnew}),
    .re    (accept && proc),
    .raddr (cg_c),
    .rdata (grd)
  );

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        pwin[r][0] <= pwin[r][1];
        pwin[r][1] <= pwin[r][2];
      end
      pwin[0][2] <= prd[2*PIX_W-1:PIX_W];
      pwin[1][2] <= prd[PIX_W-1:0];
      pwin[2][2] <= it_pix;
    end
    if (state == ST_STORE) begin
      for (int r = 0; r < 3; r++) begin
        gwin[r][0] <= gwin[r][1];
        gwin[r][1] <= gwin[r][2];
      end
      gwin[0][2] <= grd[19:10];
      gwin[1][2] <= grd[9:0];
      gwin[2][2] <= gnew;
    end
  end

  sgnms_grad #(.TAN_FRAC_BITS(TAN_FRAC_BITS)) u_grad (
    .clk   (clk),
    .rst   (rst),
    .start (grad_start),
    .win   (pwin),
    .done  (grad_done),
    .grad  (grad)
  );

  assign gnew = it_gint ? grad : '0;

  // Suppression compares the centre with its unsuppressed neighbours.
  always_comb begin
    cen = gwin[1][1];
    case (dir_code_t'(cen.dir))
      DIR_0: begin
        n1 = gwin[1][0].mag;
        n2 = gwin[1][2].mag;
      end
      DIR_45: begin
        n1 = gwin[0][2].mag;
        n2 = gwin[2][0].mag;
      end
      DIR_90: begin
        n1 = gwin[0][1].mag;
        n2 = gwin[2][1].mag;
      end
      default: begin
        n1 = gwin[0][0].mag;
        n2 = gwin[2][2].mag;
      end
    endcase
    if (it_sint) begin
      d_c = cen.dir;
      m_c = ((cen.mag < n1) || (cen.mag < n2)) ? '0 : cen.mag;
    end else begin
      d_c = '0;
      m_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'b0, (m_c >= lower_threshold), (m_c > upper_threshold), d_c, m_c};
      m_axis_tlast <= it_eof;
    end
  end

endmodule

### rtl/sgnms_ram.sv
module sgnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sgnms_grad.sv
module sgnms_grad import sgnms_pkg::*; #(
  parameter int TAN_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  pix_win_t win,
  output logic     done,
  output grad_t    grad
);

  localparam int TW = TAN_FRAC_BITS + 2;
  localparam int PW = TW + ABS_W;
  localparam logic [63:0] T22_FULL =
    (TAN22_Q40 + (64'd1 << (39 - TAN_FRAC_BITS))) >> (40 - TAN_FRAC_BITS);
  localparam logic [TW-1:0] T22 = T22_FULL[TW-1:0];
  localparam logic [TW-1:0] T67 = TW'(T22_FULL + (64'd2 << TAN_FRAC_BITS));

  gstate_t state, state_next;

  logic [ABS_W-1:0] left, right, top, bottom;
  logic signed [ABS_W:0] gx_c, gy_c;
  logic [ABS_W-1:0] ax_c, ay_c;

  logic [ABS_W-1:0] ax, ay;
  logic             gx_pos, gy_pos;
  logic [SQ_W-1:0]  sq;
  logic [PW-1:0]    p22, p67, lhs;
  logic [DIR_W-1:0] dir;
  logic [MAG_W-1:0] root;
  logic [2:0]       bit_idx;
  logic [MAG_W-1:0] cand;
  logic [2*MAG_W-1:0] cand_sq;

  always_comb begin
    left   = ABS_W'(win[0][0]) + ABS_W'({win[1][0], 1'b0}) + ABS_W'(win[2][0]);
    right  = ABS_W'(win[0][2]) + ABS_W'({win[1][2], 1'b0}) + ABS_W'(win[2][2]);
    top    = ABS_W'(win[0][0]) + ABS_W'({win[0][1], 1'b0}) + ABS_W'(win[0][2]);
    bottom = ABS_W'(win[2][0]) + ABS_W'({win[2][1], 1'b0}) + ABS_W'(win[2][2]);
    gx_c = $signed({1'b0, right}) - $signed({1'b0, left});
    gy_c = $signed({1'b0, top}) - $signed({1'b0, bottom});
    ax_c = gx_c[ABS_W] ? ABS_W'(-gx_c) : gx_c[ABS_W-1:0];
    ay_c = gy_c[ABS_W] ? ABS_W'(-gy_c) : gy_c[ABS_W-1:0];
    cand    = root | (MAG_W'(1) << bit_idx);
    cand_sq = cand * cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      G_IDLE: begin
        if (start) begin
          state_next = G_MUL;
        end
      end
      G_MUL:  state_next = G_DIR;
      G_DIR:  state_next = G_ROOT;
      G_ROOT: begin
        if (bit_idx == 3'd0) begin
          state_next = G_DONE;
        end
      end
      G_DONE: begin
        done       = 1'b1;
        state_next = G_IDLE;
      end
      default: state_next = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: begin
        if (start) begin
          ax     <= ax_c;
          ay     <= ay_c;
          gx_pos <= !gx_c[ABS_W] && (gx_c != '0);
          gy_pos <= !gy_c[ABS_W] && (gy_c != '0);
        end
      end
      G_MUL: begin
        sq  <= SQ_W'(ax * ax) + SQ_W'(ay * ay);
        p22 <= PW'(ax) * PW'(T22);
        p67 <= PW'(ax) * PW'(T67);
        lhs <= PW'(ay) << TAN_FRAC_BITS;
      end
      G_DIR: begin
        if (lhs <= p22) begin
          dir <= DIR_0;
        end else if (lhs >= p67) begin
          dir <= DIR_90;
        end else if (gx_pos == gy_pos) begin
          dir <= DIR_45;
        end else begin
          dir <= DIR_135;
        end
        root    <= '0;
        bit_idx <= 3'd7;
      end
      G_ROOT: begin
        if (SQ_W'(cand_sq) <= sq) begin
          root <= cand;
        end
        bit_idx <= bit_idx - 3'd1;
      end
      default: begin
      end
    endcase
  end

  // Sums of squares of 65536 and above saturate the magnitude.
  assign grad.mag = (sq[SQ_W-1:16] != '0) ? '1 : root;
  assign grad.dir = dir;

endmodule

### rtl/sgnms_checker.sv
module sgnms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat present after reset");

  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("new beat taken while a pixel is being processed");

  a_strong_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[7:0] != 8'd0)
    else $error("strong flag on a zero magnitude");

endmodule

bind sobel_gradient_nonmax_suppress sgnms_checker u_checker (.*);
